/* hw/rtl/bxde_pkg.sv */
// ----------------------------------------------------------------------------
// bxde_pkg
// Shared types, codes and helpers of the binary cross dilate/erode unit.
// ----------------------------------------------------------------------------
package bxde_pkg;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPERATION    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd600;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd600;

  // The integer mean of three components exceeds 128 exactly when the sum
  // reaches three times 129.
  localparam logic [9:0] WHITE_MIN_SUM = 10'd387;

  // The column stores are split into three banks by column modulo three, so
  // that a column and both of its neighbors sit in different banks.
  localparam int          BANKS     = 3;
  localparam logic [1:0]  BANK_LAST = 2'd2;
  localparam logic [1:0]  BANK_ZERO = 2'd0;

  typedef struct packed {
    logic upper;
    logic center;
  } row_pair_t;

  typedef struct packed {
    logic is_pixel;
    logic produce;
    logic has_left;
    logic has_right;
    logic has_up;
    logic last;
    logic px;
  } xctrl_t;

  function automatic logic [1:0] bank_inc(input logic [1:0] b);
    bank_inc = (b == BANK_LAST) ? BANK_ZERO : b + 2'd1;
  endfunction

  function automatic logic [1:0] bank_dec(input logic [1:0] b);
    bank_dec = (b == BANK_ZERO) ? BANK_LAST : b - 2'd1;
  endfunction

endpackage

/* hw/rtl/binary_cross_dilate_erode_unit.sv */
// ----------------------------------------------------------------------------
// binary_cross_dilate_erode_unit
// Binarizes a raster RGB stream and applies one dilation or erosion pass with
// a four-neighbor cross, one row behind the input.
//
//   channel   direction  handshake           contents
//   s_axis    in         s_tvalid/s_tready   pixel or drain word
//   m_axis    out        m_tvalid/m_tready   binary result word
//   cfg       in         cfg_we              operation, width, height
//
// One word is accepted per clock while the output is not stalled, and a result
// passes through the stage register and the output register. The rate is set by
// the banked column stores, read once per word and written once per pixel word,
// with the newest write forwarded into the next read. Reset is synchronous;
// the stores need no clearing. A stalled output holds the word in flight, and
// the input waits only while the output word is full and not taken.
// ----------------------------------------------------------------------------
module binary_cross_dilate_erode_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // red, green, blue
  input  logic                                s_tuser,   // kind
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // pixel_white, zero fill
  output logic                                m_tlast,   // last_of_frame
  input  logic                                cfg_we,
  input  logic [bxde_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bxde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH / 3 + 1;
  localparam int AW    = $clog2(DEPTH);

  logic                               operation;
  logic [bxde_pkg::WIDTH_REG_W-1:0]   image_width;
  logic [bxde_pkg::HEIGHT_REG_W-1:0]  image_height;

  logic                 advance, stage_valid, rd_en, wr_en, pixel_white;
  bxde_pkg::xctrl_t     stage_ctrl;
  logic [CW-1:0]        stage_col;
  logic [1:0]           stage_bank, wr_bank;
  logic [AW-1:0]        stage_addr, wr_addr;
  logic [AW-1:0]        rd_addr [bxde_pkg::BANKS];
  bxde_pkg::row_pair_t  rd_data [bxde_pkg::BANKS];
  bxde_pkg::row_pair_t  wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation    <= bxde_pkg::OP_DILATE;
      image_width  <= bxde_pkg::WIDTH_RESET;
      image_height <= bxde_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bxde_pkg::CFG_OPERATION: begin
          operation <= cfg_data[0];
        end
        bxde_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[bxde_pkg::WIDTH_REG_W-1:0];
        end
        bxde_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  bxde_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .kind         (s_tuser),
    .red          (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .image_width  (image_width),
    .image_height (image_height),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .stage_ctrl   (stage_ctrl),
    .stage_col    (stage_col),
    .stage_bank   (stage_bank),
    .stage_addr   (stage_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  bxde_row_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bxde_cross #(.MAX_WIDTH(MAX_WIDTH)) u_cross (
    .clk           (clk),
    .rst           (rst),
    .operation     (operation),
    .stage_valid   (stage_valid),
    .stage_ctrl    (stage_ctrl),
    .stage_col     (stage_col),
    .stage_bank    (stage_bank),
    .stage_addr    (stage_addr),
    .rd_data       (rd_data),
    .advance       (advance),
    .wr_en         (wr_en),
    .wr_bank       (wr_bank),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .pixel_white   (pixel_white),
    .last_of_frame (m_tlast)
  );

  assign m_tdata = {7'd0, pixel_white};

endmodule

/* hw/rtl/bxde_row_store.sv */
// ----------------------------------------------------------------------------
// bxde_row_store
// Three banks of column pairs (upper row, center row), one read and one write
// port per bank, read data registered.
// ----------------------------------------------------------------------------
module bxde_row_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr [bxde_pkg::BANKS],
  output bxde_pkg::row_pair_t        rd_data [bxde_pkg::BANKS],
  input  logic                       wr_en,
  input  logic [1:0]                 wr_bank,
  input  logic [AW-1:0]              wr_addr,
  input  bxde_pkg::row_pair_t        wr_data
);

  localparam int DEPTH = MAX_WIDTH / 3 + 1;
  localparam int AW    = $clog2(DEPTH);

  for (genvar b = 0; b < bxde_pkg::BANKS; b++) begin : g_bank
    bxde_pkg::row_pair_t mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

endmodule

/* hw/rtl/bxde_front.sv */
// ----------------------------------------------------------------------------
// bxde_front
// Input side: binarizes pixels, keeps the pixel and drain positions, issues
// the bank reads and holds the word while the reads complete.
// ----------------------------------------------------------------------------
module bxde_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  logic                                kind,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  input  logic [bxde_pkg::WIDTH_REG_W-1:0]    image_width,
  input  logic [bxde_pkg::HEIGHT_REG_W-1:0]   image_height,
  input  logic                                advance,
  output logic                                stage_valid,
  output bxde_pkg::xctrl_t                    stage_ctrl,
  output logic [CW-1:0]                       stage_col,
  output logic [1:0]                          stage_bank,
  output logic [AW-1:0]                       stage_addr,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr [bxde_pkg::BANKS]
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = MAX_WIDTH / 3 + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [CW-1:0]                     input_column;
  logic [1:0]                        input_bank;
  logic [AW-1:0]                     input_addr;
  logic [bxde_pkg::ROW_W-1:0]        input_row;
  logic [CW-1:0]                     drain_column;
  logic [1:0]                        drain_bank;
  logic [AW-1:0]                     drain_addr;

  logic [WW-1:0]                     w_eff;
  logic [bxde_pkg::HEIGHT_REG_W-1:0] h_eff;
  logic [CW-1:0]                     in_col_eff, dr_col_eff, x;
  logic [1:0]                        in_bank_eff, dr_bank_eff, bx, bx_next;
  logic [AW-1:0]                     in_addr_eff, dr_addr_eff, ax, ax_next;
  logic [bxde_pkg::ROW_W-1:0]        row_eff, row_next;
  logic [bxde_pkg::HEIGHT_REG_W-1:0] row_inc;
  logic                              last_col, is_drain, accept, px;
  logic [9:0]                        sum;
  bxde_pkg::xctrl_t                  ctrl;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
  end

  assign h_eff = (image_height == '0) ? bxde_pkg::HEIGHT_REG_W'(1) : image_height;

  always_comb begin
    in_col_eff  = input_column;
    in_bank_eff = input_bank;
    in_addr_eff = input_addr;
    if (WW'(input_column) >= w_eff) begin
      in_col_eff  = '0;
      in_bank_eff = bxde_pkg::BANK_ZERO;
      in_addr_eff = '0;
    end
    dr_col_eff  = drain_column;
    dr_bank_eff = drain_bank;
    dr_addr_eff = drain_addr;
    if (WW'(drain_column) >= w_eff) begin
      dr_col_eff  = '0;
      dr_bank_eff = bxde_pkg::BANK_ZERO;
      dr_addr_eff = '0;
    end
    row_eff = (bxde_pkg::HEIGHT_REG_W'(input_row) >= h_eff) ? '0 : input_row;
  end

  assign is_drain = (kind == bxde_pkg::KIND_DRAIN);
  assign x        = is_drain ? dr_col_eff : in_col_eff;
  assign bx       = is_drain ? dr_bank_eff : in_bank_eff;
  assign ax       = is_drain ? dr_addr_eff : in_addr_eff;
  assign last_col = (WW'(x) + WW'(1)) == w_eff;
  assign bx_next  = bxde_pkg::bank_inc(bx);
  assign ax_next  = ax + AW'(bx == bxde_pkg::BANK_LAST);
  assign row_inc  = bxde_pkg::HEIGHT_REG_W'(row_eff) + bxde_pkg::HEIGHT_REG_W'(1);
  assign row_next = (row_inc >= h_eff) ? '0 : bxde_pkg::ROW_W'(row_inc);

  assign sum = 10'(red) + 10'(green) + 10'(blue);
  assign px  = (sum >= bxde_pkg::WHITE_MIN_SUM);

  always_comb begin
    ctrl.is_pixel  = !is_drain;
    ctrl.produce   = is_drain || (row_eff != '0);
    ctrl.has_left  = (x != '0);
    ctrl.has_right = !last_col;
    ctrl.has_up    = is_drain ? (h_eff != bxde_pkg::HEIGHT_REG_W'(1))
                              : (row_eff >= bxde_pkg::ROW_W'(2));
    ctrl.last      = is_drain && last_col;
    ctrl.px        = px;
  end

  assign s_ready = !stage_valid || advance;
  assign accept  = s_valid && s_ready;
  assign rd_en   = accept;

  // Each bank is read at whichever of the columns left, center or right
  // falls into it.
  always_comb begin
    for (int b = 0; b < bxde_pkg::BANKS; b++) begin
      if (2'(b) == bx) begin
        rd_addr[b] = ax;
      end else if (2'(b) == bx_next) begin
        rd_addr[b] = ax_next;
      end else begin
        rd_addr[b] = ax - AW'(bx == bxde_pkg::BANK_ZERO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column <= '0;
      input_bank   <= bxde_pkg::BANK_ZERO;
      input_addr   <= '0;
      input_row    <= '0;
      drain_column <= '0;
      drain_bank   <= bxde_pkg::BANK_ZERO;
      drain_addr   <= '0;
    end else if (accept) begin
      input_column <= in_col_eff;
      input_bank   <= in_bank_eff;
      input_addr   <= in_addr_eff;
      input_row    <= row_eff;
      drain_column <= dr_col_eff;
      drain_bank   <= dr_bank_eff;
      drain_addr   <= dr_addr_eff;
      if (is_drain) begin
        if (last_col) begin
          drain_column <= '0;
          drain_bank   <= bxde_pkg::BANK_ZERO;
          drain_addr   <= '0;
        end else begin
          drain_column <= x + CW'(1);
          drain_bank   <= bx_next;
          drain_addr   <= ax_next;
        end
      end else begin
        if (last_col) begin
          input_column <= '0;
          input_bank   <= bxde_pkg::BANK_ZERO;
          input_addr   <= '0;
          input_row    <= row_next;
        end else begin
          input_column <= x + CW'(1);
          input_bank   <= bx_next;
          input_addr   <= ax_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_ctrl <= ctrl;
      stage_col  <= x;
      stage_bank <= bx;
      stage_addr <= ax;
    end
  end

endmodule

/* hw/rtl/bxde_cross.sv */
// ----------------------------------------------------------------------------
// bxde_cross
// Applies the cross rule to the read column pairs, writes the updated pair
// back with forwarding of the newest write, and holds the output word.
// ----------------------------------------------------------------------------
module bxde_cross #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 operation,
  input  logic                 stage_valid,
  input  bxde_pkg::xctrl_t     stage_ctrl,
  input  logic [CW-1:0]        stage_col,
  input  logic [1:0]           stage_bank,
  input  logic [AW-1:0]        stage_addr,
  input  bxde_pkg::row_pair_t  rd_data [bxde_pkg::BANKS],
  output logic                 advance,
  output logic                 wr_en,
  output logic [1:0]           wr_bank,
  output logic [AW-1:0]        wr_addr,
  output bxde_pkg::row_pair_t  wr_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic                 pixel_white,
  output logic                 last_of_frame
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH / 3 + 1;
  localparam int AW    = $clog2(DEPTH);

  logic                 lw_valid;
  logic [CW-1:0]        lw_col;
  bxde_pkg::row_pair_t  lw_data;

  bxde_pkg::row_pair_t  ent_self, ent_left, ent_right;
  logic                 left_v, right_v, up_v, self_v, any_white, any_black;
  logic                 result, out_free;

  // The newest write may not yet be visible in the registered read data.
  always_comb begin
    ent_self  = rd_data[stage_bank];
    ent_left  = rd_data[bxde_pkg::bank_dec(stage_bank)];
    ent_right = rd_data[bxde_pkg::bank_inc(stage_bank)];
    if (lw_valid && lw_col == stage_col) begin
      ent_self = lw_data;
    end
    if (lw_valid && lw_col == stage_col - CW'(1)) begin
      ent_left = lw_data;
    end
    if (lw_valid && lw_col == stage_col + CW'(1)) begin
      ent_right = lw_data;
    end
  end

  always_comb begin
    self_v  = ent_self.center;
    up_v    = ent_self.upper;
    right_v = ent_right.center;
    left_v  = stage_ctrl.is_pixel ? ent_left.upper : ent_left.center;
    any_white = (stage_ctrl.has_left && left_v) || (stage_ctrl.has_right && right_v)
             || (stage_ctrl.has_up && up_v) || (stage_ctrl.is_pixel && stage_ctrl.px);
    any_black = (stage_ctrl.has_left && !left_v) || (stage_ctrl.has_right && !right_v)
             || (stage_ctrl.has_up && !up_v) || (stage_ctrl.is_pixel && !stage_ctrl.px);
    if (operation == bxde_pkg::OP_ERODE) begin
      result = self_v && !any_black;
    end else begin
      result = self_v || any_white;
    end
  end

  assign out_free = !m_valid || m_ready;
  assign advance  = stage_valid && (!stage_ctrl.produce || out_free);

  assign wr_en          = advance && stage_ctrl.is_pixel;
  assign wr_bank        = stage_bank;
  assign wr_addr        = stage_addr;
  assign wr_data.upper  = self_v;
  assign wr_data.center = stage_ctrl.px;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_col  <= stage_col;
      lw_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance && stage_ctrl.produce) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_ctrl.produce) begin
      pixel_white   <= result;
      last_of_frame <= stage_ctrl.last;
    end
  end

endmodule
